### hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  hash_t;
  typedef logic [15:0][31:0] block_t;

  // control from the sequencer to the round core
  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  // status from the round core back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  localparam int unsigned ROUNDS = 64;

  // initial hash values, word 0 in slot 0
  localparam hash_t HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // round constants
  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### hw/rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Streams a message one byte per transfer, pads it and emits the eight
// SHA-256 digest words.
// ----------------------------------------------------------------------------
//  channel   handshake        payload                              dir
//  command   start / busy     data_byte, has_byte, last_item       in
//  result    done (strobe)    digest_word, word_index, last_word   out
//
//  a byte that does not complete a 64-byte block leaves the hasher idle
//  a byte that completes a block goes through start, 64 rounds of the
//  shared round unit, then the feed-forward add
//  a close pads one byte per cycle (9 to 72 bytes), pausing for one or two block
//  compressions, then streams 8 digest words on consecutive cycles
//  synchronous reset restores the initial hash values; no clearing pass
//  results cannot be stalled: each word is valid for exactly one cycle
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last_item,
  output logic        done,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KICK = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [7:0] PAD_MARK = 8'h80;

  logic [2:0]  state;
  logic [2:0]  after;
  logic [5:0]  pos;
  logic [63:0] bit_length;
  logic        sent_80;
  logic        len_phase;
  logic [2:0]  out_idx;

  sha256_pkg::block_t     block;
  sha256_pkg::hash_t      hash;
  sha256_pkg::core_ctrl_t ctrl;
  sha256_pkg::core_stat_t stat;

  logic       put_en;
  logic [7:0] put_val;
  logic       len_sel;
  logic       wrap;
  logic       accept;

  assign accept  = start && (state == ST_IDLE);
  assign len_sel = sent_80 && ((pos == LEN_POS) || len_phase);
  assign wrap    = put_en && (pos == LAST_POS);

  // byte source: message byte or padding byte
  always_comb begin
    put_en  = 1'b0;
    put_val = '0;
    unique case (state)
      ST_IDLE: begin
        put_en  = start && has_byte;
        put_val = data_byte;
      end
      ST_PAD: begin
        put_en = 1'b1;
        if (!sent_80) begin
          put_val = PAD_MARK;
        end else if (len_sel) begin
          put_val = bit_length[{~pos[2:0], 3'b000} +: 8];
        end
      end
      default: ;
    endcase
  end

  // byte packing into big-endian block words
  always_ff @(posedge clk) begin
    if (put_en) begin
      case (pos[1:0])
        2'd0:    block[pos[5:2]]        <= {put_val, 24'd0};
        2'd1:    block[pos[5:2]][23:16] <= put_val;
        2'd2:    block[pos[5:2]][15:8]  <= put_val;
        default: block[pos[5:2]][7:0]   <= put_val;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      after      <= ST_IDLE;
      pos        <= '0;
      bit_length <= '0;
      sent_80    <= 1'b0;
      len_phase  <= 1'b0;
      out_idx    <= '0;
    end else begin
      if (put_en) begin
        pos <= pos + 6'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (has_byte) begin
              bit_length <= bit_length + 64'd8;
            end
            if (wrap) begin
              state <= ST_KICK;
              after <= last_item ? ST_PAD : ST_IDLE;
            end else if (last_item) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          sent_80 <= 1'b1;
          if (len_sel) begin
            len_phase <= 1'b1;
          end
          if (wrap) begin
            state <= ST_KICK;
            after <= len_sel ? ST_OUT : ST_PAD;
          end
        end
        ST_KICK: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (stat.done) begin
            state <= after;
          end
        end
        ST_OUT: begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            state      <= ST_IDLE;
            bit_length <= '0;
            sent_80    <= 1'b0;
            len_phase  <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // core control
  assign ctrl.start = (state == ST_KICK);
  assign ctrl.init  = (state == ST_OUT) && (out_idx == 3'd7);

  sha256_round_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .block (block),
    .stat  (stat),
    .hash  (hash)
  );

  // outputs
  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_OUT);
  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = done && (out_idx == 3'd7);

  // digest words come out in order
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (done && !last_word) |=> (done && (word_index == $past(word_index) + 3'd1)))
    else $error("digest word order broken");

  // block returns to idle right after the final word
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    (done && last_word) |=> !busy)
    else $error("not idle after digest");

  // the round unit is never restarted while in use
  a_core_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !stat.busy)
    else $error("round unit started while busy");

  // a full block always goes to the round unit
  a_wrap_kick: assert property (@(posedge clk) disable iff (rst)
    wrap |=> (state == ST_KICK))
    else $error("full block not compressed");

  // no transfer is taken while a message is being finished
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD) |-> !accept)
    else $error("transfer accepted during padding");

endmodule

### hw/rtl/sha256_round_core.sv
// ----------------------------------------------------------------------------
// sha256_round_core
// Holds the chaining words and compresses one 512-bit block, one round per
// cycle, with a 16-word sliding schedule window.
// ----------------------------------------------------------------------------
module sha256_round_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::core_ctrl_t ctrl,
  input  sha256_pkg::block_t     block,
  output sha256_pkg::core_stat_t stat,
  output sha256_pkg::hash_t      hash
);

  sha256_pkg::hash_t  work;
  sha256_pkg::block_t sched;
  logic               run;
  logic               fin;
  logic [5:0]         rnd;

  sha256_pkg::word_t  t1;
  sha256_pkg::word_t  t2;
  sha256_pkg::word_t  w_new;
  sha256_pkg::word_t  choose;
  sha256_pkg::word_t  major;

  // round datapath
  always_comb begin
    choose = (work[4] & work[5]) ^ (~work[4] & work[6]);
    major  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1     = work[7] + sha256_pkg::big_sigma1(work[4]) + choose
             + sha256_pkg::ROUND_K[rnd] + sched[0];
    t2     = sha256_pkg::big_sigma0(work[0]) + major;
    w_new  = sched[0] + sha256_pkg::small_sigma0(sched[1]) + sched[9]
             + sha256_pkg::small_sigma1(sched[14]);
  end

  // round sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      rnd <= '0;
    end else begin
      fin <= 1'b0;
      if (ctrl.start) begin
        run <= 1'b1;
        rnd <= '0;
      end else if (run) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'(sha256_pkg::ROUNDS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // working registers and schedule window
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      work  <= hash;
      sched <= block;
    end else if (run) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= w_new;
    end
  end

  // chaining words: feed-forward add after the last round
  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      hash <= sha256_pkg::HASH_INIT;
    end else if (fin) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end
  end

  assign stat.busy = run | fin;
  assign stat.done = fin;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams messages byte by byte into sha256_message_hasher and checks every
// digest word against a SHA-256 model kept in the bench. Covers the empty
// message, a close carried with the last byte or on its own, idle items,
// messages that fill whole blocks and messages whose padding spills into an
// extra block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RANDOM_ITEMS = 460;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned SETTLE       = 300;
  localparam int unsigned PRINT_LIMIT  = 40;

  // one byte transfer as queued for the driver
  typedef struct {
    logic [7:0]  data;
    logic        has;
    logic        last;
    int unsigned gap_pct;
    bit          hold_for_drain;
  } feed_item_t;

  // one digest word as it should appear on the result ports
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        last_item = 1'b0;
  logic        busy;
  logic        done;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // hash model state
  logic [31:0] hash_chain [8];
  logic [31:0] msg_block [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  feed_item_t    feed_queue [$];
  digest_entry_t digest_expect [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned msgs_hashed = 0;
  int unsigned bytes_hashed = 0;
  int unsigned words_checked = 0;
  int unsigned longest_msg = 0;

  sha256_message_hasher uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .data_byte   (data_byte),
    .has_byte    (has_byte),
    .last_item   (last_item),
    .done        (done),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  always #10 clk = ~clk;

  // cycle counter for the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH @%0t %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hasher_clear();
    for (int i = 0; i < 8; i++) hash_chain[i] = SHA_IV[i];
    msg_bits = '0;
    fill_pos = '0;
  endfunction

  // 64 rounds over the current block, then the feed-forward add
  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
             + ((e & f) ^ (~e & g)) + SHA_K[i] + sched[i];
      t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
  endfunction

  // big-endian byte placement, compress on a full block
  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned slot;
    int unsigned sh;
    slot = 32'(fill_pos[5:2]);
    sh = 24 - 8 * fill_pos[1:0];
    if (fill_pos[1:0] == 2'd0)
      msg_block[slot] = {24'h0, b} << sh;
    else
      msg_block[slot] |= {24'h0, b} << sh;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_block();
  endfunction

  // expected digest words for one accepted transfer
  function automatic void predict_transfer(input logic [7:0] b, input logic has,
                                           input logic close);
    logic [63:0] len;
    digest_entry_t ent;
    if (has) begin
      msg_bits = msg_bits + 64'd8;
      bytes_hashed++;
      absorb_byte(b);
    end
    if (close) begin
      len = msg_bits;
      if (len[63:3] > 61'(longest_msg)) longest_msg = 32'(len[63:3]);
      absorb_byte(8'h80);
      while (fill_pos != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        ent.word  = hash_chain[i];
        ent.index = i[2:0];
        ent.last  = (i == 7);
        digest_expect.insert(digest_expect.size(), ent);
      end
      msgs_hashed++;
      hasher_clear();
    end
  endfunction

  function automatic void queue_item(input logic [7:0] b, input logic has, input logic close,
                                     input int unsigned gap, input bit hold);
    feed_item_t it;
    it.data = b;
    it.has = has;
    it.last = close;
    it.gap_pct = gap;
    it.hold_for_drain = hold;
    feed_queue.insert(feed_queue.size(), it);
  endfunction

  // one message of n random bytes with stray idle items; returns items queued
  function automatic int unsigned queue_message(input int unsigned n, input int unsigned gap,
                                                input bit hold);
    bit close_with_byte;
    bit first;
    int unsigned counted;
    close_with_byte = (n != 0) && ($urandom_range(1) == 1);
    first = hold;
    counted = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0) begin
        queue_item(8'($urandom_range(255)), 1'b0, 1'b0, gap, first);
        first = 1'b0;
        counted++;
      end
      queue_item(8'($urandom_range(255)), 1'b1, close_with_byte && (k == n - 1), gap, first);
      first = 1'b0;
      counted++;
    end
    if (!close_with_byte) begin
      queue_item(8'($urandom_range(255)), 1'b0, 1'b1, gap, first);
      counted++;
    end
    return counted;
  endfunction

  // driver: predict on each accepted transfer, then present the next item
  always @(posedge clk) begin : drive_proc
    feed_item_t nxt;
    logic go;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_transfer(data_byte, has_byte, last_item);
      if (!start || !busy) begin
        if (feed_queue.size() != 0) begin
          if (feed_queue[0].hold_for_drain && digest_expect.size() != 0)
            go = 1'b0;
          else if ($urandom_range(99) < feed_queue[0].gap_pct)
            go = 1'b0;
          else
            go = 1'b1;
        end
        if (go) begin
          nxt = feed_queue.pop_front();
          data_byte <= nxt.data;
          has_byte  <= nxt.has;
          last_item <= nxt.last;
        end
        start <= go;
      end
    end
  end

  // monitor: each strobed word against the oldest expectation
  always @(posedge clk) begin : check_proc
    digest_entry_t want;
    if (!rst && done) begin
      if (digest_expect.size() == 0) begin
        report_mismatch("digest word with none expected", digest_word, 32'h0);
      end else begin
        want = digest_expect.pop_front();
        words_checked++;
        if (digest_word !== want.word)
          report_mismatch("digest_word", digest_word, want.word);
        if (word_index !== want.index)
          report_mismatch("word_index", {29'h0, word_index}, {29'h0, want.index});
        if (last_word !== want.last)
          report_mismatch("last_word", {31'h0, last_word}, {31'h0, want.last});
      end
    end
  end

  // run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // stimulus and end of run
  initial begin : main_proc
    int unsigned fed;
    int unsigned msg_len;
    int unsigned pick;
    int unsigned gap;
    int unsigned phase_no;
    int unsigned prev_phase;
    int unsigned waited;

    hasher_clear();

    // directed: idle item, empty message, close with byte, close alone
    queue_item(8'hff, 1'b0, 1'b0, 28, 1'b0);
    queue_item(8'h5a, 1'b0, 1'b1, 28, 1'b0);
    queue_item(8'h61, 1'b1, 1'b0, 28, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0, 28, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1, 28, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0, 28, 1'b0);
    queue_item(8'hff, 1'b1, 1'b0, 28, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0, 28, 1'b0);
    queue_item(8'h80, 1'b1, 1'b0, 28, 1'b0);
    queue_item(8'hff, 1'b0, 1'b1, 28, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 0, 1'b0);
    queue_item(8'h7f, 1'b1, 1'b1, 0, 1'b0);

    // random messages: mostly short, many around the padding boundary
    fed = 0;
    prev_phase = 0;
    while (fed < RANDOM_ITEMS) begin
      phase_no = (fed < RANDOM_ITEMS / 3) ? 1 : (fed < 2 * RANDOM_ITEMS / 3) ? 2 : 3;
      gap = (phase_no == 1) ? 28 : (phase_no == 2) ? 85 : 0;
      pick = $urandom_range(99);
      if (pick < 50)
        msg_len = $urandom_range(20);
      else if (pick < 78)
        msg_len = $urandom_range(66, 52);
      else if (pick < 95)
        msg_len = $urandom_range(51, 21);
      else
        msg_len = $urandom_range(140, 110);
      fed += queue_message(msg_len, gap, phase_no != prev_phase);
      prev_phase = phase_no;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (feed_queue.size() != 0 || start) @(posedge clk);
    waited = 0;
    while (digest_expect.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (digest_expect.size() != 0)
      report_mismatch("digest words never arrived", digest_expect.size(), 32'h0);

    $display("hashed %0d messages, %0d bytes, longest %0d bytes", msgs_hashed,
             bytes_hashed, longest_msg);
    $display("checked %0d digest words, %0d mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
